FILE: rtl/wft_pkg.sv
package wft_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned MaxWordLen   = 16;
  localparam int unsigned CountBits    = 32;
  // cells between candidate registers in the query chain
  localparam int unsigned RegStep      = 8;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned UsedW = $clog2(TableEntries + 1);
  localparam int unsigned LenW = 5;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2,
    OP_TOPK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_BAD_PARM = 2'd3
  } status_e;

  // one table entry as carried along the chain
  typedef struct packed {
    logic [63:0]          word_low;
    logic [63:0]          word_high;
    logic [LenW-1:0]      word_length;
    logic [CountBits-1:0] count;
  } entry_t;

  // control fanned out to every cell
  typedef struct packed {
    logic clear;      // drop all entries
    logic commit;     // present pending word for match/insert
    logic scan_start; // reset the per-query emitted marks
    logic scan_mark;  // mark the cell holding the winner
  } cell_ctrl_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  // byte order compare: true when word a is before word b (unsigned bytes)
  function automatic logic word_before(input logic [127:0] a, input logic [127:0] b);
    logic res;
    logic done;
    res  = 1'b0;
    done = 1'b0;
    for (int p = 0; p < 16; p++) begin
      if (!done && a[8*p +: 8] != b[8*p +: 8]) begin
        res  = a[8*p +: 8] < b[8*p +: 8];
        done = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/wft_cell.sv
// One table slot. Matches the pending word, takes an insert when it is the
// first empty slot, and during a query compares its entry against the best
// candidate handed in from the left neighbor.
module wft_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wft_pkg::cell_ctrl_t      ctrl_i,
  input  wft_pkg::entry_t          pend_i,
  input  logic                     prev_full_i,
  output logic                     full_o,
  output logic                     hit_o,
  // query chain
  input  logic                     best_vld_i,
  input  wft_pkg::entry_t          best_i,
  input  logic [wft_pkg::IdxW-1:0] best_idx_i,
  input  logic [wft_pkg::IdxW-1:0] my_idx_i,
  input  logic [wft_pkg::IdxW-1:0] mark_idx_i,
  output logic                     best_vld_o,
  output wft_pkg::entry_t          best_o,
  output logic [wft_pkg::IdxW-1:0] best_idx_o
);

  logic            full_q, full_d;
  logic            done_q, done_d;
  wft_pkg::entry_t ent_q, ent_d;
  logic            match;
  logic            ins;
  logic            beats;

  assign match = full_q && ent_q.word_low == pend_i.word_low &&
                 ent_q.word_high == pend_i.word_high &&
                 ent_q.word_length == pend_i.word_length;
  assign hit_o  = match;
  assign full_o = full_q;
  assign ins    = ctrl_i.commit && !full_q && prev_full_i;

  always_comb begin
    full_d = full_q;
    ent_d  = ent_q;
    done_d = done_q;
    if (ctrl_i.clear) begin
      full_d = 1'b0;
    end else if (ctrl_i.commit) begin
      if (match && ent_q.count != wft_pkg::CountMax) begin
        ent_d.count = ent_q.count + 1'b1;
      end
    end
    // insert gated at top by "no hit anywhere"; pend_i carries count 1
    if (ins && !ctrl_i.clear) begin
      full_d = 1'b1;
      ent_d  = pend_i;
    end
    if (ctrl_i.scan_start) begin
      done_d = 1'b0;
    end else if (ctrl_i.scan_mark && mark_idx_i == my_idx_i) begin
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      full_q <= full_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_comb begin
    beats = 1'b0;
    if (full_q && !done_q) begin
      if (!best_vld_i) begin
        beats = 1'b1;
      end else if (ent_q.count != best_i.count) begin
        beats = ent_q.count > best_i.count;
      end else begin
        beats = wft_pkg::word_before({ent_q.word_high, ent_q.word_low},
                                     {best_i.word_high, best_i.word_low});
      end
    end
  end

  assign best_vld_o = best_vld_i || beats;
  assign best_o     = beats ? ent_q : best_i;
  assign best_idx_o = beats ? my_idx_i : best_idx_i;

endmodule

FILE: rtl/wft_chain.sv
// Row of table cells. The query candidate is registered every RegStep cells
// so the compare chain is pipelined; a full scan result appears after the
// chain latency.
module wft_chain (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wft_pkg::cell_ctrl_t      ctrl_i,
  input  wft_pkg::entry_t          pend_i,
  input  logic [wft_pkg::IdxW-1:0] mark_idx_i,
  output logic                     hit_o,
  output logic                     best_vld_o,
  output wft_pkg::entry_t          best_o,
  output logic [wft_pkg::IdxW-1:0] best_idx_o
);

  localparam int unsigned N = wft_pkg::TableEntries;

  logic [N:0]                     full_c;
  logic [N-1:0]                   hit_c;
  logic [N:0]                     bv;
  wft_pkg::entry_t [N:0]          be;
  logic [N:0][wft_pkg::IdxW-1:0]  bi;
  wft_pkg::cell_ctrl_t            cc;

  assign full_c[0] = 1'b1;
  assign bv[0]     = 1'b0;
  assign be[0]     = '0;
  assign bi[0]     = '0;

  // suppress insert on hit: on a hit only the matching cell sees commit
  logic any_hit;
  assign any_hit = |hit_c;
  assign hit_o   = any_hit;

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic                     bv_o;
    wft_pkg::entry_t          be_o;
    logic [wft_pkg::IdxW-1:0] bi_o;
    wft_pkg::cell_ctrl_t      gctl;

    always_comb begin
      gctl = ctrl_i;
      gctl.commit = ctrl_i.commit && (hit_c[g] || !any_hit);
    end

    wft_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i      (gctl),
      .pend_i      (pend_i),
      .prev_full_i (full_c[g]),
      .full_o      (full_c[g+1]),
      .hit_o       (hit_c[g]),
      .best_vld_i  (bv[g]),
      .best_i      (be[g]),
      .best_idx_i  (bi[g]),
      .my_idx_i    (wft_pkg::IdxW'(g)),
      .mark_idx_i  (mark_idx_i),
      .best_vld_o  (bv_o),
      .best_o      (be_o),
      .best_idx_o  (bi_o)
    );

    if ((g % wft_pkg::RegStep) == wft_pkg::RegStep - 1) begin : g_reg
      logic                     bv_q;
      wft_pkg::entry_t          be_q;
      logic [wft_pkg::IdxW-1:0] bi_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          bv_q <= 1'b0;
        end else begin
          bv_q <= bv_o;
        end
      end
      always_ff @(posedge clk_i) begin
        be_q <= be_o;
        bi_q <= bi_o;
      end
      assign bv[g+1] = bv_q;
      assign be[g+1] = be_q;
      assign bi[g+1] = bi_q;
    end else begin : g_wire
      assign bv[g+1] = bv_o;
      assign be[g+1] = be_o;
      assign bi[g+1] = bi_o;
    end
  end

  assign cc         = ctrl_i;
  assign best_vld_o = bv[N] && !cc.clear;
  assign best_o     = be[N];
  assign best_idx_o = bi[N];

endmodule

FILE: rtl/word_frequency_table_top_k.sv
// Text byte and clear take effect at the accepting edge (busy stays low). End of text moves
// to S_END, which then registers its result (busy while in S_END). Top-k with k zero or
// an empty table answers in the next cycle. Otherwise one scan per result: after S_START,
// S_WAIT waits while the candidate passes the chain (one candidate register per RegStep
// cells), then S_EMIT gives the result. Throughput: one byte per cycle while busy is low.
// Reset: async active low, table empty, no pending word. Results are one-cycle strobes.
module word_frequency_table_top_k (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  text_byte_i,
  input  logic [7:0]  k_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [6:0]  distinct_words_o,
  output logic        entry_valid_o,
  output logic [63:0] word_low_o,
  output logic [63:0] word_high_o,
  output logic [4:0]  word_length_o,
  output logic [31:0] occurrences_o,
  output logic [5:0]  rank_o,
  output logic        last_o
);

  localparam int unsigned ScanLat = wft_pkg::TableEntries / wft_pkg::RegStep;
  localparam int unsigned WaitW = $clog2(ScanLat + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_END   = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [63:0]               plow_q, plow_d, phigh_q, phigh_d;
  logic [wft_pkg::LenW-1:0]  plen_q, plen_d;
  logic                      inw_q, inw_d;
  logic                      ovf_q, ovf_d;
  logic [wft_pkg::UsedW-1:0] used_q, used_d;
  logic [7:0]                left_q, left_d;
  logic [5:0]                rank_q, rank_d;
  logic [WaitW-1:0]          wait_q, wait_d;

  wft_pkg::cell_ctrl_t       ctrl;
  wft_pkg::entry_t           pend;
  logic                      hit;
  logic                      bvld;
  wft_pkg::entry_t           bent;
  logic [wft_pkg::IdxW-1:0]  bidx;
  logic                      acc;
  logic                      commit;

  logic                      vo_q, vo_d;
  logic [1:0]                st_q, st_d;
  logic                      ev_q, ev_d;
  wft_pkg::entry_t           oe_q, oe_d;
  logic [5:0]                ork_q, ork_d;
  logic                      ol_q, ol_d;

  assign acc  = start && !busy;
  assign busy = state_q != S_IDLE;

  assign pend.word_low    = plow_q;
  assign pend.word_high   = phigh_q;
  assign pend.word_length = plen_q;
  assign pend.count       = wft_pkg::CountBits'(1);

  wft_chain u_chain (
    .clk_i,
    .rst_ni,
    .ctrl_i     (ctrl),
    .pend_i     (pend),
    .mark_idx_i (bidx),
    .hit_o      (hit),
    .best_vld_o (bvld),
    .best_o     (bent),
    .best_idx_o (bidx)
  );

  always_comb begin
    state_d = state_q;
    plow_d  = plow_q;
    phigh_d = phigh_q;
    plen_d  = plen_q;
    inw_d   = inw_q;
    ovf_d   = ovf_q;
    used_d  = used_q;
    left_d  = left_q;
    rank_d  = rank_q;
    wait_d  = wait_q;
    ctrl    = '0;
    commit  = 1'b0;
    vo_d    = 1'b0;
    st_d    = '0;
    ev_d    = 1'b0;
    oe_d    = '0;
    ork_d   = '0;
    ol_d    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          case (wft_pkg::op_e'(operation_i))
            wft_pkg::OP_CLEAR: begin
              ctrl.clear = 1'b1;
              plow_d = '0; phigh_d = '0; plen_d = '0; inw_d = 1'b0;
              ovf_d = 1'b0; used_d = '0;
            end
            wft_pkg::OP_BYTE: begin
              if (wft_pkg::is_word_byte(text_byte_i)) begin
                inw_d = 1'b1;
                if (plen_q < wft_pkg::LenW'(wft_pkg::MaxWordLen)) begin
                  if (plen_q < 5'd8) begin
                    plow_d[8*plen_q[2:0] +: 8] = text_byte_i;
                  end else begin
                    phigh_d[8*plen_q[2:0] +: 8] = text_byte_i;
                  end
                  plen_d = plen_q + 1'b1;
                end
              end else begin
                commit = inw_q;
              end
            end
            wft_pkg::OP_END: begin
              commit  = inw_q;
              state_d = S_END;
            end
            default: begin
              if (k_i == '0) begin
                vo_d = 1'b1; st_d = wft_pkg::ST_BAD_PARM; ol_d = 1'b1;
              end else if (used_q == '0) begin
                vo_d = 1'b1; st_d = wft_pkg::ST_EMPTY; ol_d = 1'b1;
              end else begin
                left_d  = (8'(used_q) < k_i) ? 8'(used_q) : k_i;
                rank_d  = '0;
                state_d = S_START;
              end
            end
          endcase
          if (commit) begin
            ctrl.commit = 1'b1;
            if (!hit) begin
              if (used_q < wft_pkg::UsedW'(wft_pkg::TableEntries)) begin
                used_d = used_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            plow_d = '0; phigh_d = '0; plen_d = '0; inw_d = 1'b0;
          end
        end
      end
      S_END: begin
        vo_d = 1'b1;
        ol_d = 1'b1;
        st_d = ovf_q ? wft_pkg::ST_OVERFLOW :
               (used_q == '0 ? wft_pkg::ST_EMPTY : wft_pkg::ST_OK);
        state_d = S_IDLE;
      end
      S_START: begin
        ctrl.scan_start = 1'b1;
        wait_d  = WaitW'(ScanLat);
        state_d = S_WAIT;
      end
      S_WAIT: begin
        // chain holds steady; candidate ripples through registers
        if (wait_q == '0) begin
          state_d = S_EMIT;
        end else begin
          wait_d = wait_q - 1'b1;
        end
      end
      S_EMIT: begin
        ctrl.scan_mark = 1'b1;
        vo_d  = 1'b1;
        st_d  = ovf_q ? wft_pkg::ST_OVERFLOW : wft_pkg::ST_OK;
        ev_d  = bvld;
        oe_d  = bent;
        ork_d = rank_q;
        left_d = left_q - 1'b1;
        rank_d = rank_q + 1'b1;
        if (left_q == 8'd1) begin
          ol_d    = 1'b1;
          state_d = S_IDLE;
        end else begin
          wait_d  = WaitW'(ScanLat);
          state_d = S_WAIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      plow_q  <= '0;
      phigh_q <= '0;
      plen_q  <= '0;
      inw_q   <= 1'b0;
      ovf_q   <= 1'b0;
      used_q  <= '0;
      left_q  <= '0;
      rank_q  <= '0;
      wait_q  <= '0;
      vo_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      plow_q  <= plow_d;
      phigh_q <= phigh_d;
      plen_q  <= plen_d;
      inw_q   <= inw_d;
      ovf_q   <= ovf_d;
      used_q  <= used_d;
      left_q  <= left_d;
      rank_q  <= rank_d;
      wait_q  <= wait_d;
      vo_q    <= vo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    ev_q  <= ev_d;
    oe_q  <= oe_d;
    ork_q <= ork_d;
    ol_q  <= ol_d;
  end

  assign valid_o          = vo_q;
  assign status_o         = st_q;
  assign distinct_words_o = 7'(used_q);
  assign entry_valid_o    = ev_q;
  assign word_low_o       = oe_q.word_low;
  assign word_high_o      = oe_q.word_high;
  assign word_length_o    = oe_q.word_length;
  assign occurrences_o    = 32'(oe_q.count);
  assign rank_o           = ork_q;
  assign last_o           = ol_q;

endmodule

FILE: rtl/wft_checker.sv
module wft_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       valid_o,
  input logic       entry_valid_o,
  input logic [5:0] rank_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  // a non-entry result always closes its request
  a_nonentry_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !entry_valid_o |-> last_o) else $error("non-entry result without last");

  // busy only follows an accepted request
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without request");

  // entries carry ok or overflow only
  a_entry_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && entry_valid_o |->
      (status_o == wft_pkg::ST_OK || status_o == wft_pkg::ST_OVERFLOW))
    else $error("bad entry status");

  // the list is still running while more entries follow
  a_list_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && entry_valid_o && !last_o |-> busy)
    else $error("list entry while idle");

  // non-entry results carry rank zero
  a_nonentry_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !entry_valid_o |-> rank_o == 6'd0)
    else $error("rank on non-entry result");

endmodule

bind word_frequency_table_top_k wft_checker u_wft_checker (
  .clk_i, .rst_ni, .start, .busy, .valid_o, .entry_valid_o, .rank_o, .status_o, .last_o
);
